// ===== hw/rtl/epds_pkg.sv =====
// Shared types and constants for the arc dedup symmetrizer.
package epds_pkg;

  localparam int unsigned FieldW     = 32;
  localparam int unsigned OwnerW     = 16;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned TableSlots = 1024;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_LOCAL_FIRST = 1'b0,
    CFG_LOCAL_END   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                      operation;
    logic [FieldW-1:0]         edge_source;
    logic [FieldW-1:0]         edge_target;
    logic signed [FieldW-1:0]  edge_weight;
    logic [OwnerW-1:0]         target_owner;
    logic [IdxW-1:0]           read_index;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]           forward_index;
    logic                      merged;
    logic                      reverse_stored;
    logic                      send_valid;
    logic [FieldW-1:0]         send_source;
    logic [FieldW-1:0]         send_target;
    logic signed [FieldW-1:0]  send_weight;
    logic [OwnerW-1:0]         send_owner;
    logic                      table_full;
    logic [FieldW-1:0]         read_source;
    logic [FieldW-1:0]         read_target;
    logic signed [FieldW-1:0]  read_weight;
  } out_item_t;

  // Classified command from front to back.
  typedef struct packed {
    in_item_t item;
    logic     tgt_local;
  } cmd_t;

  localparam logic [63:0] HashK1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HashK2 = 64'hC2B2AE3D27D4EB4F;

  function automatic logic signed [FieldW-1:0] sat_add(
    input logic signed [FieldW-1:0] a,
    input logic signed [FieldW-1:0] b
  );
    logic signed [FieldW:0] s;
    s = {a[FieldW-1], a} + {b[FieldW-1], b};
    if (s[FieldW] != s[FieldW-1]) begin
      sat_add = s[FieldW] ? {1'b1, {(FieldW-1){1'b0}}} : {1'b0, {(FieldW-1){1'b1}}};
    end else begin
      sat_add = s[FieldW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/edge_pair_dedup_symmetrizer.sv =====
// Top level of the arc dedup symmetrizer.
// Usage:
//   Input queue port: drive in_data and raise in_push; a transfer happens on
//   a clock edge with in_push high and in_full low. A two-entry command queue
//   sits in front of the table engine; commands are registered in it.
//   Result queue port: out_data is valid while out_empty is low; pop it with
//   out_pop. Exactly one result per input item, in input order.
//   Config: cfg_we with cfg_index 0 (local_first) or 1 (local_end) and
//   cfg_wdata; write only while idle.
// Steps (engine, one item at a time):
//   S_IDLE takes the command. A read then passes S_RDWAIT. An insert passes
//   S_HASH0 to S_HASH3 (hashing), then S_SLOT and S_CHECK for a free slot or
//   S_SLOT, S_CHECK, S_ARC, S_CMP per occupied slot probed (slot read, arc
//   read, compare); S_DONE hands over the result; a local reverse arc repeats
//   hashing and probing. The probe loop over the single-port stores sets the rate.
// Reset: rst_n low clears arc count, registers and queues; then a clearing
//   pass over all 1024 slots empties the slot marks before the first command.
// Stall: when the result register is occupied and not popped, the engine
//   holds its finished result and the input queue fills, then in_full rises.
module edge_pair_dedup_symmetrizer #(
  parameter int unsigned VERTEX_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  epds_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output epds_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import epds_pkg::*;

  logic [31:0] local_first_r, local_end_r;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_first_r <= '0;
      local_end_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_FIRST: local_first_r <= cfg_wdata;
        CFG_LOCAL_END:   local_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  epds_front #(.VERTEX_BITS(VERTEX_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .local_first(local_first_r), .local_end(local_end_r),
    .cmd_valid, .cmd_take, .cmd
  );

  epds_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .out_empty, .out_pop, .out_data
  );
endmodule

// ===== hw/rtl/epds_front.sv =====
// Front end: input transfer, vertex masking and locality check, two-entry command queue.
module epds_front #(
  parameter int unsigned VERTEX_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  epds_pkg::in_item_t      in_data,
  input  logic [31:0]             local_first,
  input  logic [31:0]             local_end,
  output logic                    cmd_valid,
  input  logic                    cmd_take,
  output epds_pkg::cmd_t          cmd
);
  import epds_pkg::*;

  localparam int unsigned VB = (VERTEX_BITS < FieldW) ? VERTEX_BITS : FieldW;
  localparam logic [FieldW-1:0] VMask = (VB >= FieldW) ? {FieldW{1'b1}} :
                                        FieldW'((64'd1 << VB) - 64'd1);

  cmd_t       q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c;
  logic       push_ok;

  always_comb begin
    c = '0;
    c.item = in_data;
    c.item.edge_source = in_data.edge_source & VMask;
    c.item.edge_target = in_data.edge_target & VMask;
    c.tgt_local = (c.item.edge_target >= local_first) && (c.item.edge_target < local_end);
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (cmd_take && cmd_valid);
    wr_nxt  = wr_r ^ push_ok;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, cmd_take && cmd_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= c;
    end
  end
endmodule

// ===== hw/rtl/epds_back.sv =====
// Back end: hashing, slot probing, arc stores, result register.
module epds_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  epds_pkg::cmd_t       cmd,
  output logic                 out_empty,
  input  logic                 out_pop,
  output epds_pkg::out_item_t  out_data
);
  import epds_pkg::*;

  localparam int unsigned SW = $clog2(TableSlots);
  localparam int unsigned CW = SW + 1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_HASH0  = 13'b0000000000010,
    S_HASH1  = 13'b0000000000100,
    S_HASH2  = 13'b0000000001000,
    S_SLOT   = 13'b0000000010000,
    S_CHECK  = 13'b0000000100000,
    S_ARC    = 13'b0000001000000,
    S_CMP    = 13'b0000010000000,
    S_MERGE  = 13'b0000100000000,
    S_RDWAIT = 13'b0001000000000,
    S_DONE   = 13'b0010000000000,
    S_HASH3  = 13'b0100000000000,
    S_CLEAR  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic                   slot_vld_mem   [TableSlots];
  logic [CW-1:0]          slot_ref_mem   [TableSlots];
  logic [FieldW-1:0]      arc_src_mem    [TableSlots];
  logic [FieldW-1:0]      arc_tgt_mem    [TableSlots];
  logic [FieldW-1:0]      arc_wgt_mem    [TableSlots];

  cmd_t              c_r;
  logic              rev_r;
  logic [FieldW-1:0] s_r, t_r;
  logic [63:0]       m_lo_r, p1_r, h_r;
  logic [31:0]       m_hi_r;
  logic [SW-1:0]     slot_r;
  logic [SW-1:0]     clr_r;
  logic [CW-1:0]     probes_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     ref_r;
  logic [FieldW-1:0] rsrc_r, rtgt_r, rwgt_r;
  logic              slot_v_r;
  out_item_t         acc_r;
  out_item_t         res_r;
  logic              full_r, full_nxt;
  logic              done_go;

  logic [63:0] hx;
  logic [SW-1:0] slot_inc;
  logic [SW-1:0] arc_addr;
  assign hx = h_r ^ (h_r >> 29);
  assign slot_inc = (slot_r == SW'(TableSlots - 1)) ? '0 : slot_r + SW'(1);
  assign arc_addr = (state_r == S_IDLE) ? cmd.item.read_index : ref_r[SW-1:0];

  assign done_go   = (state_r == S_DONE) && (!full_r || out_pop);
  assign full_nxt  = done_go || (full_r && !out_pop);
  assign out_empty = !full_r;
  assign out_data  = res_r;
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    if (state_r == S_SLOT) begin
      ref_r    <= slot_ref_mem[slot_r];
      slot_v_r <= slot_vld_mem[slot_r];
    end
    if (state_r == S_CHECK || state_r == S_IDLE) begin
      rsrc_r <= arc_src_mem[arc_addr];
      rtgt_r <= arc_tgt_mem[arc_addr];
      rwgt_r <= arc_wgt_mem[arc_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd_valid) state_nxt = (cmd.item.operation == OP_READ) ? S_RDWAIT : S_HASH0;
      S_CLEAR:  state_nxt = S_CLEAR;
      S_HASH0:  state_nxt = S_HASH1;
      S_HASH1:  state_nxt = S_HASH2;
      S_HASH2:  state_nxt = S_HASH3;
      S_HASH3:  state_nxt = S_SLOT;
      S_SLOT:   state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_ARC;
      S_ARC:    state_nxt = S_CMP;
      S_CMP:    state_nxt = S_DONE;
      S_MERGE:  state_nxt = S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      full_r  <= 1'b0;
    end else begin
      full_r <= full_nxt;
      unique case (state_r)
        S_CLEAR: begin
          slot_vld_mem[clr_r] <= 1'b0;
          clr_r <= clr_r + SW'(1);
          if (clr_r == SW'(TableSlots - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c_r   <= cmd;
            rev_r <= 1'b0;
            s_r   <= cmd.item.edge_source;
            t_r   <= cmd.item.edge_target;
            acc_r <= '0;
            state_r <= state_nxt;
          end
        end
        S_HASH0: begin
          m_lo_r  <= {32'd0, s_r} * {32'd0, HashK1[31:0]};
          m_hi_r  <= s_r * HashK1[63:32];
          state_r <= S_HASH1;
        end
        S_HASH1: begin
          p1_r    <= m_lo_r + {m_hi_r, 32'd0};
          m_lo_r  <= {32'd0, t_r} * {32'd0, HashK2[31:0]};
          m_hi_r  <= t_r * HashK2[63:32];
          state_r <= S_HASH2;
        end
        S_HASH2: begin
          h_r <= p1_r + m_lo_r + {m_hi_r, 32'd0};
          state_r <= S_HASH3;
        end
        S_HASH3: begin
          slot_r   <= hx[SW-1:0];
          probes_r <= '0;
          state_r  <= S_SLOT;
        end
        S_SLOT: state_r <= S_CHECK;
        S_CHECK: begin
          if (!slot_v_r) begin
            if (count_r >= CW'(TableSlots)) begin
              acc_r.table_full <= 1'b1;
              acc_r.forward_index <= rev_r ? acc_r.forward_index : '0;
              state_r <= S_DONE;
            end else begin
              arc_src_mem[count_r[SW-1:0]] <= s_r;
              arc_tgt_mem[count_r[SW-1:0]] <= t_r;
              arc_wgt_mem[count_r[SW-1:0]] <= c_r.item.edge_weight;
              slot_ref_mem[slot_r] <= count_r;
              slot_vld_mem[slot_r] <= 1'b1;
              count_r <= count_r + CW'(1);
              if (!rev_r) begin
                acc_r.forward_index <= IdxW'(count_r);
                if (c_r.tgt_local) begin
                  rev_r <= 1'b1;
                  s_r <= t_r;
                  t_r <= s_r;
                  state_r <= S_HASH0;
                end else begin
                  acc_r.send_valid  <= 1'b1;
                  acc_r.send_source <= t_r;
                  acc_r.send_target <= s_r;
                  acc_r.send_weight <= c_r.item.edge_weight;
                  acc_r.send_owner  <= c_r.item.target_owner;
                  state_r <= S_DONE;
                end
              end else begin
                acc_r.reverse_stored <= 1'b1;
                state_r <= S_DONE;
              end
            end
          end else begin
            state_r <= S_ARC;
          end
        end
        S_ARC: state_r <= S_CMP;
        S_CMP: begin
          if (rsrc_r == s_r && rtgt_r == t_r) begin
            arc_wgt_mem[ref_r[SW-1:0]] <= sat_add(rwgt_r, c_r.item.edge_weight);
            acc_r.merged <= 1'b1;
            if (!rev_r) acc_r.forward_index <= IdxW'(ref_r);
            state_r <= S_DONE;
          end else if (probes_r == CW'(TableSlots - 1)) begin
            acc_r.table_full <= 1'b1;
            if (!rev_r) acc_r.forward_index <= '0;
            state_r <= S_DONE;
          end else begin
            probes_r <= probes_r + CW'(1);
            slot_r   <= slot_inc;
            state_r  <= S_SLOT;
          end
        end
        S_MERGE: state_r <= S_DONE;
        S_RDWAIT: begin
          if (CW'(c_r.item.read_index) < count_r) begin
            acc_r.read_source <= rsrc_r;
            acc_r.read_target <= rtgt_r;
            acc_r.read_weight <= rwgt_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            res_r   <= acc_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/epds_checker.sv =====
// Port-level checker for the arc dedup symmetrizer, with its bind.
module epds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input epds_pkg::out_item_t out_data
);
  import epds_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_data))
    else $error("result changed while stalled");
  a_one_hot_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> $countones({out_data.merged, out_data.reverse_stored,
                               out_data.send_valid}) <= 1)
    else $error("conflicting outcome flags");
  a_send_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.send_valid) |-> out_data.send_owner == '0)
    else $error("send owner without send");
endmodule

bind edge_pair_dedup_symmetrizer epds_checker u_epds_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);

// ===== bench/edge_pair_dedup_symmetrizer_tb.sv =====
// Testbench for the arc dedup symmetrizer: directed table, local-range items, random inserts and reads, table overflow.
module edge_pair_dedup_symmetrizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epds_pkg::*;

  localparam int Slots = 1024;
  localparam int CycleLimit = 60000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  edge_pair_dedup_symmetrizer dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  bit [31:0] lo_first, lo_end;
  bit tbl_valid [Slots];
  int unsigned tbl_ref [Slots];
  bit [31:0] arc_src [Slots], arc_tgt [Slots];
  bit signed [31:0] arc_wt [Slots];
  int unsigned n_arcs;

  out_item_t result_q [$];
  int errors = 0, n_items = 0, n_results = 0, n_sends = 0, n_merges = 0, n_full = 0;
  bit drain_fast = 1'b0;
  int cycles = 0;

  function automatic bit signed [31:0] sum_clamp(bit signed [31:0] a, bit signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic int unsigned slot_of(bit [31:0] s, bit [31:0] t);
    bit [63:0] h;
    h = {32'b0, s} * 64'h9E3779B97F4A7C15 + {32'b0, t} * 64'hC2B2AE3D27D4EB4F;
    h ^= h >> 29;
    return h % Slots;
  endfunction

  // 0 new, 1 merged, 2 full
  function automatic int add_arc(bit [31:0] s, bit [31:0] t, bit signed [31:0] w,
                                 output int unsigned idx);
    int unsigned sl;
    int unsigned k;
    sl = slot_of(s, t);
    idx = 0;
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_valid[sl]) begin
        if (n_arcs >= Slots) return 2;
        arc_src[n_arcs] = s; arc_tgt[n_arcs] = t; arc_wt[n_arcs] = w;
        tbl_valid[sl] = 1'b1; tbl_ref[sl] = n_arcs;
        idx = n_arcs; n_arcs++;
        return 0;
      end
      k = tbl_ref[sl];
      if (arc_src[k] == s && arc_tgt[k] == t) begin
        arc_wt[k] = sum_clamp(arc_wt[k], w);
        idx = k;
        return 1;
      end
      sl = (sl + 1) % Slots;
    end
    return 2;
  endfunction

  function automatic out_item_t symmetrize(in_item_t it);
    out_item_t r;
    int unsigned k, k2;
    int st, st2;
    r = '0;
    if (it.operation == OP_READ) begin
      if (it.read_index < n_arcs) begin
        r.read_source = arc_src[it.read_index];
        r.read_target = arc_tgt[it.read_index];
        r.read_weight = arc_wt[it.read_index];
      end
      return r;
    end
    st = add_arc(it.edge_source, it.edge_target, it.edge_weight, k);
    if (st == 2) begin
      r.table_full = 1'b1;
      return r;
    end
    r.forward_index = k[9:0];
    if (st == 1) begin
      r.merged = 1'b1;
    end else if (it.edge_target >= lo_first && it.edge_target < lo_end) begin
      st2 = add_arc(it.edge_target, it.edge_source, it.edge_weight, k2);
      if (st2 == 0) r.reverse_stored = 1'b1;
      else if (st2 == 1) r.merged = 1'b1;
      else r.table_full = 1'b1;
    end else begin
      r.send_valid = 1'b1;
      r.send_source = it.edge_target;
      r.send_target = it.edge_source;
      r.send_weight = it.edge_weight;
      r.send_owner = it.target_owner;
    end
    return r;
  endfunction

  task automatic wait_idle();
    in_push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_range(bit [31:0] first, bit [31:0] last);
    cfg_we <= 1'b1; cfg_index <= CFG_LOCAL_FIRST; cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= CFG_LOCAL_END; cfg_wdata <= last;
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_first = first;
    lo_end = last;
  endtask

  // expected result pushed at the accepting edge, before the block can answer
  task automatic send_item(in_item_t it, bit gaps);
    if (gaps && !drain_fast && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    result_q.push_back(symmetrize(it));
    n_items++;
  endtask

  function automatic in_item_t ins(bit [31:0] s, bit [31:0] t, bit [31:0] w, bit [15:0] o);
    in_item_t it;
    it = '0;
    it.operation = OP_INSERT;
    it.edge_source = s; it.edge_target = t; it.edge_weight = w; it.target_owner = o;
    return it;
  endfunction

  function automatic in_item_t rd(bit [9:0] i);
    in_item_t it;
    it = '0;
    it.operation = OP_READ;
    it.read_index = i;
    return it;
  endfunction

  // receiver with random stall bursts
  initial begin
    out_item_t e;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          e = result_q.pop_front();
          if (out_data !== e) begin
            errors++;
            if (out_data.forward_index !== e.forward_index)
              $error("forward_index exp %0d got %0d", e.forward_index, out_data.forward_index);
            if (out_data.merged !== e.merged)
              $error("merged exp %0d got %0d", e.merged, out_data.merged);
            if (out_data.reverse_stored !== e.reverse_stored)
              $error("reverse_stored exp %0d got %0d", e.reverse_stored, out_data.reverse_stored);
            if (out_data.send_valid !== e.send_valid)
              $error("send_valid exp %0d got %0d", e.send_valid, out_data.send_valid);
            if (out_data.send_source !== e.send_source)
              $error("send_source exp %h got %h", e.send_source, out_data.send_source);
            if (out_data.send_target !== e.send_target)
              $error("send_target exp %h got %h", e.send_target, out_data.send_target);
            if (out_data.send_weight !== e.send_weight)
              $error("send_weight exp %h got %h", e.send_weight, out_data.send_weight);
            if (out_data.send_owner !== e.send_owner)
              $error("send_owner exp %h got %h", e.send_owner, out_data.send_owner);
            if (out_data.table_full !== e.table_full)
              $error("table_full exp %0d got %0d", e.table_full, out_data.table_full);
            if (out_data.read_source !== e.read_source)
              $error("read_source exp %h got %h", e.read_source, out_data.read_source);
            if (out_data.read_target !== e.read_target)
              $error("read_target exp %h got %h", e.read_target, out_data.read_target);
            if (out_data.read_weight !== e.read_weight)
              $error("read_weight exp %h got %h", e.read_weight, out_data.read_weight);
          end
          n_sends += e.send_valid;
          n_merges += e.merged;
          n_full += e.table_full;
        end
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (!drain_fast && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  typedef struct {
    in_item_t item;
    bit has_exp;
    out_item_t exp_res;
  } step_t;

  initial begin
    step_t steps [$];
    step_t st;
    out_item_t z;
    in_item_t it;
    bit [31:0] base, span;
    int pick;

    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    n_arcs = 0; lo_first = 0; lo_end = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, empty local range: reads before anything stored give zero
    z = '0;
    st.item = rd(10'd0); st.has_exp = 1; st.exp_res = z; steps.push_back(st);
    st.item = rd(10'd1023); st.has_exp = 1; st.exp_res = z; steps.push_back(st);
    st.item = ins(32'h0, 32'h0, 32'h7fffffff, 16'hffff); st.has_exp = 1;
    z = '0; z.send_valid = 1; z.send_owner = 16'hffff; z.send_weight = 32'h7fffffff;
    st.exp_res = z; steps.push_back(st);
    st.item = ins(32'h0, 32'h0, 32'h1, 16'h0); st.has_exp = 1;
    z = '0; z.merged = 1; st.exp_res = z; steps.push_back(st);
    st.item = rd(10'd0); st.has_exp = 1;
    z = '0; z.read_weight = 32'h7fffffff; st.exp_res = z; steps.push_back(st);
    st.has_exp = 0;
    st.item = ins(32'hffffffff, 32'hffffffff, 32'h80000000, 16'h1234); steps.push_back(st);
    st.item = ins(32'hffffffff, 32'hffffffff, 32'h80000000, 16'h0); steps.push_back(st);
    st.item = ins(32'hffffffff, 32'h0, 32'hffffffff, 16'h5555); steps.push_back(st);
    st.item = ins(32'h0, 32'hffffffff, 32'h00010000, 16'haaaa); steps.push_back(st);
    st.item = rd(10'd1); steps.push_back(st);
    st.item = rd(10'd3); steps.push_back(st);
    st.item = rd(10'd4); steps.push_back(st);
    foreach (steps[i]) begin
      send_item(steps[i].item, 1'b0);
      if (steps[i].has_exp) result_q[$] = steps[i].exp_res;
    end

    // local range: self loop doubles, reverse merge, remote outside range
    wait_idle();
    write_range(32'd100, 32'd200);
    send_item(ins(32'd5, 32'd150, 32'h00020000, 16'd1), 1'b0);
    send_item(ins(32'd150, 32'd5, 32'h00010000, 16'd2), 1'b0);
    send_item(ins(32'd120, 32'd120, 32'h40000000, 16'd3), 1'b0);
    send_item(ins(32'd7, 32'd200, 32'h1, 16'd4), 1'b0);
    send_item(ins(32'd7, 32'd99, 32'h1, 16'd4), 1'b0);
    send_item(ins(32'd7, 32'd100, 32'hc0000000, 16'd4), 1'b0);
    send_item(ins(32'd100, 32'd7, 32'h80000000, 16'd4), 1'b0);
    for (int i = 0; i < 10; i++) send_item(rd(10'(i)), 1'b0);

    // random phases with varying local ranges; small vertex pools in the first four phases force merges
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: write_range(32'h0, 32'hffffffff);
        1: write_range(32'hffffffff, 32'h0);
        default: write_range($urandom_range(0, 40), $urandom_range(20, 64));
      endcase
      if (ph == 5) drain_fast = 1'b1;
      for (int n = 0; n < 300; n++) begin
        pick = $urandom_range(0, 9);
        span = (ph < 4) ? 64 : 32'hffffffff;
        base = (pick == 0) ? 32'hffffffc0 : 32'h0;
        if (pick < 3) begin
          it = rd(n_arcs > 0 && $urandom_range(0, 3) != 0 ?
                  10'($urandom_range(0, n_arcs - 1)) : 10'($urandom_range(0, 1023)));
        end else begin
          it = '0;
          it.operation = OP_INSERT;
          it.edge_source = (span == 32'hffffffff) ? $urandom() : base + $urandom_range(0, 63);
          it.edge_target = (span == 32'hffffffff) ? $urandom() : base + $urandom_range(0, 63);
          it.edge_weight = {$urandom()};
          it.target_owner = 16'($urandom());
        end
        send_item(it, 1'b1);
      end
    end

    // fill the table to overflow with remote-only arcs, then read back
    wait_idle();
    write_range(32'd1, 32'd0);
    while (n_arcs < Slots)
      send_item(ins($urandom(), $urandom(), $urandom(), 16'($urandom())), 1'b0);
    send_item(ins(32'h11, 32'h22, 32'h5, 16'h7), 1'b0);
    send_item(rd(10'd1023), 1'b0);
    wait_idle();

    $display("Ran %0d items, %0d results: %0d remote sends, %0d merges, %0d table-full drops.",
             n_items, n_results, n_sends, n_merges, n_full);
    if (errors == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
